[design/hashed_block_buffer_cache_assert.svh]
// Assertion macros shared by the buffer cache RTL.
`ifndef HASHED_BLOCK_BUFFER_CACHE_ASSERT_SVH
`define HASHED_BLOCK_BUFFER_CACHE_ASSERT_SVH

// Checked outside reset only.
`define HBC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("buffer cache check failed");

// Checked at every edge, reset included.
`define HBC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("buffer cache check failed");

`endif

[design/hbc_pkg.sv]
`timescale 1ns / 1ps
package hbc_pkg;

    localparam int NUM_ENTRIES = 32;
    localparam int NUM_BUCKETS = 13;
    localparam int NODE_COUNT  = NUM_ENTRIES + NUM_BUCKETS;

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int ENT_W  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int OB_W   = $clog2(NUM_BUCKETS + 1);
    localparam int GRD_W  = $clog2(NODE_COUNT + 1);

    localparam int DEV_W = 8;
    localparam int BLK_W = 32;
    localparam int IDX_W = 5;
    localparam int CNT_W = 8;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_GET     = 2'd0,
        OP_RELEASE = 2'd1,
        OP_PIN     = 2'd2,
        OP_UNPIN   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_UNUSED    = 2'd3
    } t_status;

    typedef struct packed {
        t_op              op;
        logic [DEV_W-1:0] device_id;
        logic [BLK_W-1:0] block_number;
        logic [IDX_W-1:0] entry_index;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0] result_entry;
        logic             hit;
        logic             need_read;
        t_status          status;
    } t_rsp;

endpackage

[design/hashed_block_buffer_cache.sv]
`timescale 1ns / 1ps
// Hashed buffer cache with per-bucket LRU lists.
// Request channel: drive i_req and raise start; the transaction is taken at a
// clock edge where start is high and busy is low. busy stays high while the
// transaction is worked on.
// Result channel: o_rsp is valid for exactly one cycle while o_done is high.
// The receiver cannot stall; it must take the result in that cycle.
// Tags, valid bits and counts live in one entry RAM, the list links in two
// link RAMs (next and prev), all with registered reads.
// A get reduces the block number modulo the bucket count in S_MOD, folding
// the upper bits into the low byte until one byte is left, then walks its
// bucket one node a cycle; a miss with no free entry in its own bucket walks
// the other buckets tail first, and a move to a new bucket reads the node's
// links (S_R1, S_R2) and then rewrites the links in S_W1, S_W2 and S_W3.
// Pin, unpin and release update the entry's count in S_ENT; a release that
// drops the count to zero also moves the entry to its bucket's head.
// An index beyond the cache gives its result in the cycle after the transaction.
// After reset the block runs a clearing pass over all NODE_COUNT link nodes,
// holding busy high, before it takes the first transaction.
module hashed_block_buffer_cache (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  hbc_pkg::t_req i_req,
    output logic          busy,
    output logic          o_done,
    output hbc_pkg::t_rsp o_rsp
);
    import hbc_pkg::*;

    typedef struct packed {
        logic [DEV_W-1:0] dev;
        logic [BLK_W-1:0] blk;
        logic             valid;
        logic [CNT_W-1:0] cnt;
    } t_ent;

    typedef enum logic [12:0] {
        S_INIT = 13'b0000000000001,
        S_IDLE = 13'b0000000000010,
        S_MOD  = 13'b0000000000100,
        S_HEAD = 13'b0000000001000,
        S_STEP = 13'b0000000010000,
        S_WALK = 13'b0000000100000,
        S_OBKT = 13'b0000001000000,
        S_R1   = 13'b0000010000000,
        S_R2   = 13'b0000100000000,
        S_W1   = 13'b0001000000000,
        S_W2   = 13'b0010000000000,
        S_W3   = 13'b0100000000000,
        S_ENT  = 13'b1000000000000
    } t_state;

    localparam int REM_R = NUM_ENTRIES % NUM_BUCKETS;

    // 256 modulo the bucket count, weight of the bits above the low byte
    localparam logic [BLK_W-1:0] MOD_FOLD = BLK_W'(256 % NUM_BUCKETS);
    localparam int               MOD_KMAX = 255 / NUM_BUCKETS;

    // Reset link of a node: entries pushed in index order at their bucket heads
    function automatic logic [NODE_W-1:0] reset_next(input int n);
        int b;
        int t;
        int r;
        b = n - NUM_ENTRIES;
        t = 0;
        r = n;
        if (n < NUM_ENTRIES) begin
            r = (n >= NUM_BUCKETS) ? n - NUM_BUCKETS : NUM_ENTRIES + n;
        end else if (b < NUM_ENTRIES) begin
            if (NUM_ENTRIES >= NUM_BUCKETS) begin
                t = (b >= REM_R) ? b - REM_R : b + NUM_BUCKETS - REM_R;
                r = NUM_ENTRIES - NUM_BUCKETS + t;
            end else begin
                r = b;
            end
        end
        return NODE_W'(r);
    endfunction

    function automatic logic [NODE_W-1:0] reset_prev(input int n);
        int b;
        int t;
        int r;
        b = n - NUM_ENTRIES;
        t = 0;
        r = n;
        if (n < NUM_ENTRIES) begin
            if (n + NUM_BUCKETS < NUM_ENTRIES) begin
                r = n + NUM_BUCKETS;
            end else if (NUM_ENTRIES >= NUM_BUCKETS) begin
                t = REM_R + n - (NUM_ENTRIES - NUM_BUCKETS);
                r = NUM_ENTRIES + ((t >= NUM_BUCKETS) ? t - NUM_BUCKETS : t);
            end else begin
                r = NUM_ENTRIES + n;
            end
        end else if (b < NUM_ENTRIES) begin
            r = b;
        end
        return NODE_W'(r);
    endfunction

    // Remainder of a byte: largest multiple of the bucket count not above it removed
    function automatic logic [BKT_W-1:0] byte_mod(input logic [7:0] x);
        logic [7:0] r;
        r = x;
        for (int k = 1; k <= MOD_KMAX; k++) begin
            if (x >= 8'(k * NUM_BUCKETS)) begin
                r = x - 8'(k * NUM_BUCKETS);
            end
        end
        return r[BKT_W-1:0];
    endfunction

    // Memories
    t_ent              mem_ent [NUM_ENTRIES];
    logic [NODE_W-1:0] mem_nxt [NODE_COUNT];
    logic [NODE_W-1:0] mem_prv [NODE_COUNT];

    logic              ent_we;
    logic [ENT_W-1:0]  ent_wa;
    t_ent              ent_wd;
    logic [ENT_W-1:0]  ent_ra;
    logic              nxt_we;
    logic [NODE_W-1:0] nxt_wa;
    logic [NODE_W-1:0] nxt_wd;
    logic              prv_we;
    logic [NODE_W-1:0] prv_wa;
    logic [NODE_W-1:0] prv_wd;
    logic [NODE_W-1:0] lk_ra;

    t_ent              r_ent_q;
    logic [NODE_W-1:0] r_nxt_q;
    logic [NODE_W-1:0] r_prv_q;

    // Control and working registers
    t_state            r_state, n_state;
    t_req              r_req, n_req;
    logic [BLK_W-1:0]  r_modsrc, n_modsrc;
    logic [BKT_W-1:0]  r_rem, n_rem;
    logic [NODE_W-1:0] r_n, n_n;
    logic [NODE_W-1:0] r_wh, n_wh;
    logic [NODE_W-1:0] r_h, n_h;
    logic [GRD_W-1:0]  r_g, n_g;
    logic              r_fwd, n_fwd;
    logic              r_free_v, n_free_v;
    logic [NODE_W-1:0] r_free, n_free;
    logic [OB_W-1:0]   r_ob, n_ob;
    logic [NODE_W-1:0] r_f, n_f;
    logic [NODE_W-1:0] r_nx, n_nx;
    logic [NODE_W-1:0] r_pv, n_pv;
    logic [NODE_W-1:0] r_first, n_first;
    logic [NODE_W-1:0] r_ic, n_ic;
    logic              r_done, n_done;
    t_rsp              r_rsp, n_rsp;

    logic [BLK_W-1:0]  mod_fold;
    logic [BKT_W-1:0]  mod_r;
    logic [NODE_W-1:0] link;
    logic              walk_end;
    logic              is_ent;
    t_ent              fill;
    logic              rsp_no_free;

    // Memory ports: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            mem_ent[ent_wa] <= ent_wd;
        end
        r_ent_q <= mem_ent[ent_ra];
    end

    always_ff @(posedge i_clk) begin
        if (nxt_we) begin
            mem_nxt[nxt_wa] <= nxt_wd;
        end
        r_nxt_q <= mem_nxt[lk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (prv_we) begin
            mem_prv[prv_wa] <= prv_wd;
        end
        r_prv_q <= mem_prv[lk_ra];
    end

    // One fold step of the modulo reduction, and the final byte remainder
    assign mod_fold = (r_modsrc >> 8) * MOD_FOLD
                      + {{(BLK_W-8){1'b0}}, r_modsrc[7:0]};
    assign mod_r    = byte_mod(r_modsrc[7:0]);

    assign link     = r_fwd ? r_nxt_q : r_prv_q;
    assign walk_end = (r_n == r_wh) || (r_g == GRD_W'(NODE_COUNT));
    assign is_ent   = (r_n < NODE_W'(NUM_ENTRIES));
    assign fill     = '{dev: r_req.device_id, blk: r_req.block_number,
                        valid: 1'b1, cnt: CNT_W'(1)};

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_modsrc = r_modsrc;
        n_rem    = r_rem;
        n_n      = r_n;
        n_wh     = r_wh;
        n_h      = r_h;
        n_g      = r_g;
        n_fwd    = r_fwd;
        n_free_v = r_free_v;
        n_free   = r_free;
        n_ob     = r_ob;
        n_f      = r_f;
        n_nx     = r_nx;
        n_pv     = r_pv;
        n_first  = r_first;
        n_ic     = r_ic;
        n_done   = 1'b0;
        n_rsp    = r_rsp;
        ent_we   = 1'b0;
        ent_wa   = r_n[ENT_W-1:0];
        ent_wd   = r_ent_q;
        ent_ra   = r_n[ENT_W-1:0];
        nxt_we   = 1'b0;
        nxt_wa   = r_f;
        nxt_wd   = r_f;
        prv_we   = 1'b0;
        prv_wa   = r_f;
        prv_wd   = r_f;
        lk_ra    = r_n;

        unique case (r_state)
            S_INIT: begin
                nxt_we = 1'b1;
                nxt_wa = r_ic;
                nxt_wd = reset_next(int'(r_ic));
                prv_we = 1'b1;
                prv_wa = r_ic;
                prv_wd = reset_prev(int'(r_ic));
                ent_we = (r_ic < NODE_W'(NUM_ENTRIES));
                ent_wa = r_ic[ENT_W-1:0];
                ent_wd = '0;
                n_ic   = r_ic + NODE_W'(1);
                if (r_ic == NODE_W'(NODE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                ent_ra = ENT_W'(i_req.entry_index);
                if (start) begin
                    n_req = i_req;
                    if (i_req.op == OP_GET) begin
                        n_modsrc = i_req.block_number;
                        n_rem    = '0;
                        n_state  = S_MOD;
                    end else if (int'(i_req.entry_index) >= NUM_ENTRIES) begin
                        n_done = 1'b1;
                        n_rsp  = '{result_entry: i_req.entry_index, hit: 1'b0,
                                   need_read: 1'b0, status: ST_OK};
                    end else begin
                        n_f     = NODE_W'(i_req.entry_index);
                        n_state = S_ENT;
                    end
                end
            end
            S_MOD: begin
                if (r_modsrc[BLK_W-1:8] != '0) begin
                    n_modsrc = mod_fold;
                end else begin
                    n_rem = mod_r;
                    n_h   = NODE_W'(NUM_ENTRIES) + NODE_W'(mod_r);
                    if (r_req.op == OP_GET) begin
                        n_wh    = NODE_W'(NUM_ENTRIES) + NODE_W'(mod_r);
                        n_fwd   = 1'b1;
                        n_state = S_HEAD;
                    end else begin
                        n_state = S_R1;
                    end
                end
            end
            S_HEAD: begin
                lk_ra    = r_wh;
                n_g      = '0;
                n_free_v = r_fwd ? 1'b0 : r_free_v;
                n_state  = S_STEP;
            end
            S_STEP: begin
                n_n     = link;
                ent_ra  = link[ENT_W-1:0];
                lk_ra   = link;
                n_state = S_WALK;
            end
            S_WALK: begin
                priority if (walk_end) begin
                    if (!r_fwd) begin
                        n_ob    = r_ob + OB_W'(1);
                        n_state = S_OBKT;
                    end else if (r_free_v) begin
                        // recycle in place at the LRU end of the own bucket
                        ent_we  = 1'b1;
                        ent_wa  = r_free[ENT_W-1:0];
                        ent_wd  = fill;
                        n_done  = 1'b1;
                        n_rsp   = '{result_entry: IDX_W'(r_free), hit: 1'b0,
                                    need_read: 1'b1, status: ST_OK};
                        n_state = S_IDLE;
                    end else begin
                        n_ob    = '0;
                        n_state = S_OBKT;
                    end
                end else if (is_ent && r_fwd && r_ent_q.dev == r_req.device_id
                             && r_ent_q.blk == r_req.block_number) begin
                    ent_we       = 1'b1;
                    ent_wd.valid = 1'b1;
                    ent_wd.cnt   = (r_ent_q.cnt == COUNT_MAX) ?
                                   r_ent_q.cnt : r_ent_q.cnt + CNT_W'(1);
                    n_done  = 1'b1;
                    n_rsp   = '{result_entry: IDX_W'(r_n), hit: 1'b1,
                                need_read: !r_ent_q.valid, status: ST_OK};
                    n_state = S_IDLE;
                end else if (is_ent && !r_fwd && r_ent_q.cnt == '0) begin
                    n_f     = r_n;
                    n_state = S_R1;
                end else begin
                    if (is_ent && r_fwd && r_ent_q.cnt == '0) begin
                        n_free_v = 1'b1;
                        n_free   = r_n;
                    end
                    n_n    = link;
                    ent_ra = link[ENT_W-1:0];
                    lk_ra  = link;
                    n_g    = r_g + GRD_W'(1);
                end
            end
            S_OBKT: begin
                priority if (r_ob == OB_W'(NUM_BUCKETS)) begin
                    n_done  = 1'b1;
                    n_rsp   = '{result_entry: '0, hit: 1'b0, need_read: 1'b0,
                                status: ST_NO_FREE};
                    n_state = S_IDLE;
                end else if (OB_W'(r_rem) == r_ob) begin
                    n_ob = r_ob + OB_W'(1);
                end else begin
                    n_wh    = NODE_W'(NUM_ENTRIES) + NODE_W'(r_ob);
                    n_fwd   = 1'b0;
                    n_state = S_HEAD;
                end
            end
            S_R1: begin
                lk_ra   = r_f;
                n_state = S_R2;
            end
            S_R2: begin
                n_nx    = r_nxt_q;
                n_pv    = r_prv_q;
                lk_ra   = r_h;
                n_state = S_W1;
            end
            S_W1: begin
                // unlink; head's old first is the successor if the node led
                n_first = (r_nxt_q == r_f) ? r_nx : r_nxt_q;
                nxt_we  = 1'b1;
                nxt_wa  = r_pv;
                nxt_wd  = r_nx;
                prv_we  = 1'b1;
                prv_wa  = r_nx;
                prv_wd  = r_pv;
                n_state = S_W2;
            end
            S_W2: begin
                nxt_we  = 1'b1;
                nxt_wa  = r_f;
                nxt_wd  = r_first;
                prv_we  = 1'b1;
                prv_wa  = r_f;
                prv_wd  = r_h;
                n_state = S_W3;
            end
            S_W3: begin
                nxt_we = 1'b1;
                nxt_wa = r_h;
                nxt_wd = r_f;
                prv_we = 1'b1;
                prv_wa = r_first;
                prv_wd = r_f;
                n_done = 1'b1;
                if (r_req.op == OP_GET) begin
                    ent_we = 1'b1;
                    ent_wa = r_f[ENT_W-1:0];
                    ent_wd = fill;
                    n_rsp  = '{result_entry: IDX_W'(r_f), hit: 1'b0,
                               need_read: 1'b1, status: ST_OK};
                end else begin
                    n_rsp  = '{result_entry: r_req.entry_index, hit: 1'b0,
                               need_read: 1'b0, status: ST_OK};
                end
                n_state = S_IDLE;
            end
            S_ENT: begin
                ent_wa  = r_f[ENT_W-1:0];
                n_rsp   = '{result_entry: r_req.entry_index, hit: 1'b0,
                            need_read: 1'b0, status: ST_OK};
                n_done  = 1'b1;
                n_state = S_IDLE;
                priority if (r_req.op == OP_PIN) begin
                    ent_we     = 1'b1;
                    ent_wd.cnt = (r_ent_q.cnt == COUNT_MAX) ?
                                 r_ent_q.cnt : r_ent_q.cnt + CNT_W'(1);
                end else if (r_ent_q.cnt == '0) begin
                    n_rsp.status = ST_UNDERFLOW;
                end else begin
                    ent_we     = 1'b1;
                    ent_wd.cnt = r_ent_q.cnt - CNT_W'(1);
                    if (r_req.op == OP_RELEASE && r_ent_q.cnt == CNT_W'(1)) begin
                        // move to the MRU head of the tag's bucket
                        n_modsrc = r_ent_q.blk;
                        n_rem    = '0;
                        n_done   = 1'b0;
                        n_state  = S_MOD;
                    end
                end
            end
            default: begin
                n_state = S_INIT;
                n_ic    = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ic    <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ic    <= n_ic;
            r_done  <= n_done;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_modsrc <= n_modsrc;
        r_rem    <= n_rem;
        r_n      <= n_n;
        r_wh     <= n_wh;
        r_h      <= n_h;
        r_g      <= n_g;
        r_fwd    <= n_fwd;
        r_free_v <= n_free_v;
        r_free   <= n_free;
        r_ob     <= n_ob;
        r_f      <= n_f;
        r_nx     <= n_nx;
        r_pv     <= n_pv;
        r_first  <= n_first;
        r_rsp    <= n_rsp;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    assign rsp_no_free = o_done && (o_rsp.status == ST_NO_FREE);

    `include "hashed_block_buffer_cache_assert.svh"

    `HBC_ASSERT(a_accept_progress, (start && !busy) |=> (busy || o_done))
    `HBC_ASSERT(a_hit_ok, (o_done && o_rsp.hit) |-> (o_rsp.status == ST_OK))
    `HBC_ASSERT(a_nofree_clean, rsp_no_free |-> ({o_rsp.result_entry, o_rsp.hit} == '0))
    `HBC_ASSERT_ALWAYS(a_init_quiet, (!i_rst_n) |=> (busy && !o_done))

endmodule
